// ----- rtl/core/spch_pkg.sv -----
// spring chain euler step: shared types, codes and saturating fixed-point helpers
// no dependencies; imported by spch_iter_unit and spring_chain_euler_step
package spch_pkg;

  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned SQRT_STEPS = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_LATCH = 2'd1,
    FUNC_STEP  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    REG_JOINT_COUNT    = 3'd0,
    REG_INV_MASS       = 3'd1,
    REG_VISCOUS        = 3'd2,
    REG_GRAVITY        = 3'd3,
    REG_SPRING_GAIN    = 3'd4,
    REG_NATURAL_FACTOR = 3'd5,
    REG_TIME_STEP      = 3'd6
  } reg_e;

  typedef enum logic {
    ITER_DIV  = 1'b0,
    ITER_SQRT = 1'b1
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_LOAD, ST_TADD, ST_TCHK, ST_TMOD, ST_ROOT,
    ST_SRA, ST_SRB, ST_SD, ST_SSQ, ST_SACC, ST_SQGO, ST_SQW,
    ST_GR, ST_MAG, ST_MAGL, ST_FM, ST_FDGO, ST_FDW, ST_SEGEND, ST_JNEXT,
    ST_URD, ST_UVIS, ST_UF, ST_UA, ST_UG, ST_UTV, ST_UNV, ST_UNP,
    ST_LRM, ST_LRW, ST_LKM, ST_LKW,
    ST_ERX, ST_ERY, ST_ERZ, ST_EOUT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // q16.16 product back to q16.16, floor and saturate
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    return sat32(p >>> 16);
  endfunction

endpackage

// ----- rtl/core/spring_chain_euler_step.sv -----
// spring chain euler step: top level, sequencer over position/velocity/rest/stiffness memories
// depends on spch_pkg and spch_iter_unit
//
// An item is taken when start is high and busy is low; busy stays high until the item is done,
// so one item is worked at a time. A latch item runs one square root per segment (n-1 segments).
// A step item runs up to MAX_STEPS physics steps, each with one square root and up to three
// divides per segment on the shared one-bit-per-cycle divider, then emits the position of every
// joint; when time is still left at the step limit, one more divide drops the excess. Results are
// shown for one cycle each on out_strobe_o and cannot be held off.
module spring_chain_euler_step
  import spch_pkg::*;
#(
  parameter int unsigned MAX_JOINTS = 16,
  parameter int unsigned MAX_STEPS  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [3:0]         joint_index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [30:0]        elapsed_time_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  output logic               out_strobe_o,
  output logic [3:0]         out_joint_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [3:0]         steps_run_o,
  output logic               time_clipped_o,
  output logic               last_o
);

  localparam int unsigned JW    = $clog2(MAX_JOINTS);
  localparam int unsigned NW    = $clog2(MAX_JOINTS + 1);
  localparam int unsigned DEPTH = 3 * MAX_JOINTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(MAX_STEPS + 1);

  function automatic logic [AW-1:0] jaddr(input logic [JW-1:0] j, input logic [1:0] c);
    return AW'({j, 1'b0}) + AW'(j) + AW'(c);
  endfunction

  // configuration
  logic [4:0]  jcount_q;
  logic [30:0] inv_mass_q, viscous_q, gravity_q, gain_q, natf_q, tstep_q;

  // control
  state_e          state_q, state_d;
  logic [1:0]      c_q, c_d, c_inc;
  logic [JW-1:0]   seg_q, seg_d, jnt_q, jnt_d;
  logic [SW-1:0]   steps_q, steps_d;
  logic            clip_q, clip_d;
  logic [31:0]     rem_q, rem_d;
  logic            strobe_q, strobe_d;

  // item
  func_e              func_q;
  logic [3:0]         jidx_q;
  logic signed [31:0] root_q [3];
  logic [30:0]        elapsed_q;

  // datapath
  logic signed [63:0] prod_q;
  logic signed [31:0] mul_a, mul_b;
  logic [63:0]        sum_q;
  logic signed [31:0] pa_q, len_q, growth_q, mag_q, v_q, p_q, f_q, a_q, rest_q, ex_q, ey_q;
  logic signed [31:0] d_q [3];
  logic signed [31:0] fup_q [3];
  logic signed [31:0] fdown_q [3];
  logic               sign_q;

  // outputs
  logic [3:0]         out_joint_q, steps_out_q;
  logic signed [31:0] out_x_q, out_y_q, out_z_q;
  logic               clip_out_q, last_q;

  // memories
  logic signed [31:0] pos_mem [DEPTH];
  logic signed [31:0] vel_mem [DEPTH];
  logic signed [31:0] rest_mem [MAX_JOINTS];
  logic signed [31:0] stiff_mem [MAX_JOINTS];
  logic [DEPTH-1:0]      pos_vld_q, vel_vld_q;
  logic [MAX_JOINTS-1:0] rest_vld_q, stiff_vld_q;
  logic signed [31:0] pos_rd_q, vel_rd_q, rest_rd_q, stiff_rd_q;
  logic               pos_we, vel_we, pos_re, vel_re, rs_re, rest_we, stiff_we;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic signed [31:0] pos_wdata, vel_wdata, rs_wdata;

  // iterative unit
  iter_req_t   iter_req;
  iter_stat_t  iter_stat;
  logic [63:0] iter_opa, iter_quo;
  logic [31:0] iter_opb, iter_rem;

  // derived
  logic [NW-1:0]      nj;
  logic [30:0]        ts_eff;
  logic [31:0]        ts_u;
  logic signed [31:0] ts_s;
  logic               jnt_last, jnt_more, seg_more, latch_mode, ld_ok, len_zero, clip_now;
  logic [JW-1:0]      jidx_j;
  logic [63:0]        prod_abs;
  logic signed [31:0] len_sat, fdiv_res;

  always_comb begin
    if (jcount_q < 5'd2) begin
      nj = NW'(2);
    end else if (32'(jcount_q) > 32'(MAX_JOINTS)) begin
      nj = NW'(MAX_JOINTS);
    end else begin
      nj = NW'(jcount_q);
    end
  end

  assign ts_eff     = (tstep_q == '0) ? 31'd1 : tstep_q;
  assign ts_u       = {1'b0, ts_eff};
  assign ts_s       = $signed(ts_u);
  assign c_inc      = c_q + 2'd1;
  assign jnt_last   = (NW'(jnt_q) + NW'(1)) == nj;
  assign jnt_more   = (NW'(jnt_q) + NW'(1)) < nj;
  assign seg_more   = (NW'(seg_q) + NW'(2)) < nj;
  assign latch_mode = (func_q == FUNC_LATCH);
  assign ld_ok      = 32'(joint_index_i) < 32'(MAX_JOINTS);
  assign jidx_j     = JW'(jidx_q);
  assign len_zero   = (len_q == '0);
  assign clip_now   = (rem_q >= ts_u) && (steps_q >= SW'(MAX_STEPS));
  assign prod_abs   = prod_q[63] ? $unsigned(-prod_q) : $unsigned(prod_q);
  assign len_sat    = (iter_quo[63:31] != '0) ? 32'sh7fffffff : $signed({1'b0, iter_quo[30:0]});
  assign fdiv_res   = sat32(sign_q ? -$signed(iter_quo) : $signed(iter_quo));

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jcount_q   <= 5'd16;
      inv_mass_q <= 31'd65536;
      viscous_q  <= '0;
      gravity_q  <= '0;
      gain_q     <= 31'd65536;
      natf_q     <= 31'd65536;
      tstep_q    <= 31'd655;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_JOINT_COUNT:    jcount_q   <= cfg_data_i[4:0];
        REG_INV_MASS:       inv_mass_q <= cfg_data_i;
        REG_VISCOUS:        viscous_q  <= cfg_data_i;
        REG_GRAVITY:        gravity_q  <= cfg_data_i;
        REG_SPRING_GAIN:    gain_q     <= cfg_data_i;
        REG_NATURAL_FACTOR: natf_q     <= cfg_data_i;
        REG_TIME_STEP:      tstep_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    c_d     = c_q;
    seg_d   = seg_q;
    jnt_d   = jnt_q;
    steps_d = steps_q;
    clip_d  = clip_q;
    rem_d   = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          c_d   = '0;
          seg_d = '0;
          case (func_e'(func_i))
            FUNC_LOAD:  state_d = ld_ok ? ST_LOAD : ST_IDLE;
            FUNC_LATCH: state_d = ST_SRA;
            FUNC_STEP:  state_d = ST_TADD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        c_d = c_inc;
        if (c_q == 2'd2) begin
          c_d     = '0;
          state_d = ST_IDLE;
        end
      end
      ST_TADD: begin
        rem_d   = rem_q + 32'(elapsed_q);
        steps_d = '0;
        clip_d  = 1'b0;
        state_d = ST_TCHK;
      end
      ST_TCHK: begin
        if (clip_now) begin
          state_d = ST_TMOD;
        end else if (rem_q >= ts_u) begin
          rem_d   = rem_q - ts_u;
          c_d     = '0;
          state_d = ST_ROOT;
        end else begin
          jnt_d   = '0;
          state_d = ST_ERX;
        end
      end
      ST_TMOD: begin
        if (iter_stat.done) begin
          rem_d   = iter_rem;
          clip_d  = 1'b1;
          jnt_d   = '0;
          state_d = ST_ERX;
        end
      end
      ST_ROOT: begin
        c_d = c_inc;
        if (c_q == 2'd2) begin
          c_d     = '0;
          seg_d   = '0;
          jnt_d   = '0;
          state_d = ST_SRA;
        end
      end
      ST_SRA: state_d = ST_SRB;
      ST_SRB: state_d = ST_SD;
      ST_SD:  state_d = ST_SSQ;
      ST_SSQ: state_d = ST_SACC;
      ST_SACC: begin
        c_d     = c_inc;
        state_d = ST_SRA;
        if (c_q == 2'd2) begin
          c_d     = '0;
          state_d = ST_SQGO;
        end
      end
      ST_SQGO: state_d = ST_SQW;
      ST_SQW: begin
        if (iter_stat.done) begin
          state_d = latch_mode ? ST_LRM : ST_GR;
        end
      end
      ST_GR:   state_d = ST_MAG;
      ST_MAG:  state_d = ST_MAGL;
      ST_MAGL: state_d = ST_FM;
      ST_FM:   state_d = ST_FDGO;
      ST_FDGO: begin
        if (len_zero) begin
          c_d     = c_inc;
          state_d = ST_FM;
          if (c_q == 2'd2) begin
            c_d     = '0;
            state_d = ST_SEGEND;
          end
        end else begin
          state_d = ST_FDW;
        end
      end
      ST_FDW: begin
        if (iter_stat.done) begin
          c_d     = c_inc;
          state_d = ST_FM;
          if (c_q == 2'd2) begin
            c_d     = '0;
            state_d = ST_SEGEND;
          end
        end
      end
      ST_SEGEND: begin
        if (jnt_q == '0) begin
          jnt_d   = JW'(1);
          state_d = ST_JNEXT;
        end else begin
          state_d = ST_URD;
        end
      end
      ST_JNEXT: begin
        if (jnt_more) begin
          seg_d   = jnt_q;
          state_d = ST_SRA;
        end else begin
          state_d = ST_URD;
        end
      end
      ST_URD:  state_d = ST_UVIS;
      ST_UVIS: state_d = ST_UF;
      ST_UF:   state_d = ST_UA;
      ST_UA:   state_d = ST_UG;
      ST_UG:   state_d = ST_UTV;
      ST_UTV:  state_d = ST_UNV;
      ST_UNV:  state_d = ST_UNP;
      ST_UNP: begin
        c_d     = c_inc;
        state_d = ST_URD;
        if (c_q == 2'd2) begin
          c_d   = '0;
          jnt_d = jnt_q + JW'(1);
          if (jnt_last) begin
            steps_d = steps_q + SW'(1);
            state_d = ST_TCHK;
          end else begin
            state_d = ST_JNEXT;
          end
        end
      end
      ST_LRM: state_d = ST_LRW;
      ST_LRW: state_d = ST_LKM;
      ST_LKM: state_d = ST_LKW;
      ST_LKW: begin
        if (seg_more) begin
          seg_d   = seg_q + JW'(1);
          state_d = ST_SRA;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ERX: state_d = ST_ERY;
      ST_ERY: state_d = ST_ERZ;
      ST_ERZ: state_d = ST_EOUT;
      ST_EOUT: begin
        jnt_d   = jnt_q + JW'(1);
        state_d = jnt_last ? ST_IDLE : ST_ERX;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs: memory, multiplier and iterative unit control
  always_comb begin
    pos_we    = 1'b0;
    vel_we    = 1'b0;
    pos_re    = 1'b0;
    vel_re    = 1'b0;
    rs_re     = 1'b0;
    rest_we   = 1'b0;
    stiff_we  = 1'b0;
    wr_addr   = '0;
    rd_addr   = '0;
    pos_wdata = '0;
    vel_wdata = '0;
    rs_wdata  = qscale(prod_q);
    mul_a     = '0;
    mul_b     = '0;
    iter_req  = '{start: 1'b0, op: ITER_DIV};
    iter_opa  = '0;
    iter_opb  = '0;
    strobe_d  = 1'b0;
    case (state_q)
      ST_LOAD: begin
        pos_we    = 1'b1;
        vel_we    = 1'b1;
        wr_addr   = jaddr(jidx_j, c_q);
        pos_wdata = root_q[c_q];
      end
      ST_TCHK: begin
        if (clip_now) begin
          iter_req = '{start: 1'b1, op: ITER_DIV};
          iter_opa = 64'(rem_q);
          iter_opb = ts_u;
        end
      end
      ST_ROOT: begin
        pos_we    = 1'b1;
        wr_addr   = jaddr('0, c_q);
        pos_wdata = root_q[c_q];
      end
      ST_SRA: begin
        pos_re  = 1'b1;
        rd_addr = jaddr(seg_q, c_q);
      end
      ST_SRB: begin
        pos_re  = 1'b1;
        rd_addr = jaddr(seg_q + JW'(1), c_q);
      end
      ST_SSQ: begin
        mul_a = d_q[c_q];
        mul_b = d_q[c_q];
      end
      ST_SQGO: begin
        iter_req = '{start: 1'b1, op: ITER_SQRT};
        iter_opa = sum_q;
        rs_re    = 1'b1;
      end
      ST_MAG: begin
        mul_a = stiff_rd_q;
        mul_b = growth_q;
      end
      ST_FM: begin
        mul_a = mag_q;
        mul_b = d_q[c_q];
      end
      ST_FDGO: begin
        if (!len_zero) begin
          iter_req = '{start: 1'b1, op: ITER_DIV};
          iter_opa = prod_abs;
          iter_opb = $unsigned(len_q);
        end
      end
      ST_URD: begin
        pos_re  = 1'b1;
        vel_re  = 1'b1;
        rd_addr = jaddr(jnt_q, c_q);
      end
      ST_UVIS: begin
        mul_a = $signed({1'b0, viscous_q});
        mul_b = vel_rd_q;
      end
      ST_UA: begin
        mul_a = f_q;
        mul_b = $signed({1'b0, inv_mass_q});
      end
      ST_UTV: begin
        mul_a = ts_s;
        mul_b = a_q;
      end
      ST_UNV: begin
        vel_we    = 1'b1;
        wr_addr   = jaddr(jnt_q, c_q);
        vel_wdata = sat32(64'(v_q) + 64'(qscale(prod_q)));
        mul_a     = ts_s;
        mul_b     = v_q;
      end
      ST_UNP: begin
        pos_we    = 1'b1;
        wr_addr   = jaddr(jnt_q, c_q);
        pos_wdata = sat32(64'(p_q) + 64'(qscale(prod_q)));
      end
      ST_LRM: begin
        mul_a = $signed({1'b0, natf_q});
        mul_b = len_q;
      end
      ST_LRW: rest_we = 1'b1;
      ST_LKM: begin
        mul_a = rest_q;
        mul_b = $signed({1'b0, gain_q});
      end
      ST_LKW: stiff_we = 1'b1;
      ST_ERX: begin
        pos_re  = 1'b1;
        rd_addr = jaddr(jnt_q, 2'd0);
      end
      ST_ERY: begin
        pos_re  = 1'b1;
        rd_addr = jaddr(jnt_q, 2'd1);
      end
      ST_ERZ: begin
        pos_re  = 1'b1;
        rd_addr = jaddr(jnt_q, 2'd2);
      end
      ST_EOUT: strobe_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      c_q      <= '0;
      seg_q    <= '0;
      jnt_q    <= '0;
      steps_q  <= '0;
      clip_q   <= 1'b0;
      rem_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      c_q      <= c_d;
      seg_q    <= seg_d;
      jnt_q    <= jnt_d;
      steps_q  <= steps_d;
      clip_q   <= clip_d;
      rem_q    <= rem_d;
      strobe_q <= strobe_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          func_q    <= func_e'(func_i);
          jidx_q    <= joint_index_i;
          root_q[0] <= coord_x_i;
          root_q[1] <= coord_y_i;
          root_q[2] <= coord_z_i;
          elapsed_q <= elapsed_time_i;
        end
      end
      ST_SRA:  if (c_q == 2'd0) sum_q <= '0;
      ST_SRB:  pa_q <= pos_rd_q;
      ST_SD:   d_q[c_q] <= sat32(64'(pos_rd_q) - 64'(pa_q));
      ST_SACC: sum_q <= sum_q + $unsigned(prod_q);
      ST_SQW:  if (iter_stat.done) len_q <= len_sat;
      ST_GR:   growth_q <= sat32(64'(len_q) - 64'(rest_rd_q));
      ST_MAGL: mag_q <= qscale(prod_q);
      ST_FDGO: begin
        sign_q <= prod_q[63];
        if (len_zero) fup_q[c_q] <= '0;
      end
      ST_FDW:    if (iter_stat.done) fup_q[c_q] <= fdiv_res;
      ST_SEGEND: if (jnt_q == '0) fdown_q <= fup_q;
      ST_JNEXT:  if (!jnt_more) fup_q <= '{default: '0};
      ST_UVIS: begin
        v_q <= vel_rd_q;
        p_q <= pos_rd_q;
      end
      ST_UF: f_q <= sat32(64'(fup_q[c_q]) - 64'(fdown_q[c_q]) - 64'(qscale(prod_q)));
      ST_UG: begin
        if (c_q == 2'd1) begin
          a_q <= sat32(64'(qscale(prod_q)) - 64'(gravity_q));
        end else begin
          a_q <= qscale(prod_q);
        end
      end
      ST_UNP: if (c_q == 2'd2) fdown_q <= fup_q;
      ST_LRW: rest_q <= qscale(prod_q);
      ST_ERY: ex_q <= pos_rd_q;
      ST_ERZ: ey_q <= pos_rd_q;
      ST_EOUT: begin
        out_joint_q <= 4'(jnt_q);
        out_x_q     <= ex_q;
        out_y_q     <= ey_q;
        out_z_q     <= pos_rd_q;
        steps_out_q <= 4'(steps_q);
        clip_out_q  <= clip_q;
        last_q      <= jnt_last;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_vld_q   <= '0;
      vel_vld_q   <= '0;
      rest_vld_q  <= '0;
      stiff_vld_q <= '0;
    end else begin
      if (pos_we)   pos_vld_q[wr_addr]  <= 1'b1;
      if (vel_we)   vel_vld_q[wr_addr]  <= 1'b1;
      if (rest_we)  rest_vld_q[seg_q]   <= 1'b1;
      if (stiff_we) stiff_vld_q[seg_q]  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we)   pos_mem[wr_addr]  <= pos_wdata;
    if (vel_we)   vel_mem[wr_addr]  <= vel_wdata;
    if (rest_we)  rest_mem[seg_q]   <= rs_wdata;
    if (stiff_we) stiff_mem[seg_q]  <= rs_wdata;
    if (pos_re)   pos_rd_q <= pos_vld_q[rd_addr] ? pos_mem[rd_addr] : '0;
    if (vel_re)   vel_rd_q <= vel_vld_q[rd_addr] ? vel_mem[rd_addr] : '0;
    if (rs_re) begin
      rest_rd_q  <= rest_vld_q[seg_q]  ? rest_mem[seg_q]  : '0;
      stiff_rd_q <= stiff_vld_q[seg_q] ? stiff_mem[seg_q] : '0;
    end
  end

  spch_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .opa_i  (iter_opa),
    .opb_i  (iter_opb),
    .stat_o (iter_stat),
    .quo_o  (iter_quo),
    .rem_o  (iter_rem)
  );

  assign busy           = (state_q != ST_IDLE);
  assign out_strobe_o   = strobe_q;
  assign out_joint_o    = out_joint_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign out_z_o        = out_z_q;
  assign steps_run_o    = steps_out_q;
  assign time_clipped_o = clip_out_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_strobe_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(state_q == ST_EOUT))
    else $error("result strobe without emit state");

  a_iter_not_restarted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_req.start |-> !iter_stat.busy)
    else $error("iterative unit started while busy");

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_we && pos_re) |-> (wr_addr != rd_addr))
    else $error("position read and write of one entry in one cycle");

  a_steps_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> (steps_q < SW'(MAX_STEPS)))
    else $error("physics step beyond step limit");
`endif

endmodule

// ----- rtl/core/spch_iter_unit.sv -----
// spring chain euler step: iterative unit, 64/32 unsigned divide or 64-bit integer square root
// one bit per cycle; depends on spch_pkg
module spch_iter_unit
  import spch_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  iter_req_t   req_i,
  input  logic [63:0] opa_i,
  input  logic [31:0] opb_i,
  output iter_stat_t  stat_o,
  output logic [63:0] quo_o,
  output logic [31:0] rem_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  iter_op_e    op_q;
  logic [63:0] acc_q, res_q, bit_q;
  logic [31:0] rem_q, div_q;
  logic [31:0] shl;
  logic [63:0] trial;

  assign shl   = {rem_q[30:0], acc_q[63]};
  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (req_i.op == ITER_DIV) ? 6'(DIV_STEPS - 1) : 6'(SQRT_STEPS - 1);
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      acc_q <= opa_i;
      div_q <= opb_i;
      rem_q <= '0;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (op_q == ITER_DIV) begin
        if (shl >= div_q) begin
          rem_q <= shl - div_q;
          acc_q <= {acc_q[62:0], 1'b1};
        end else begin
          rem_q <= shl;
          acc_q <= {acc_q[62:0], 1'b0};
        end
      end else begin
        if (acc_q >= trial) begin
          acc_q <= acc_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = (op_q == ITER_SQRT) ? res_q : acc_q;
  assign rem_o       = rem_q;

endmodule
